// ----- rtl/sllg_pkg.sv -----
// sllg_pkg: shared types, widths and helpers for the stochastic spin update datapath
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
package sllg_pkg;

  localparam int SpinBits   = 16;
  localparam int FieldBits  = 24;
  localparam int NoiseBits  = 16;
  localparam int RegBits    = 32;
  localparam int CfgIdxBits = 8;

  // internal working widths
  localparam int HBits    = 32;   // effective field, Q15.16
  localparam int CBits    = 34;   // s x H after the Q1.15 shift
  localparam int EBits    = 36;   // s x c after the Q1.15 shift
  localparam int MagBits  = 36;   // magnitude fed to the gain multipliers
  localparam int NBits    = 38;   // unnormalised new spin, Q.16
  localparam int ABits    = NBits - 1;
  localparam int SaBits   = 30;   // normalised magnitudes, top in [2^29, 2^30)
  localparam int SqBits   = 2 * SaBits + 2;
  localparam int RootBits = SaBits + 1;

  localparam int SpinDrop  = (SpinBits > 16) ? SpinBits - 16 : 0;
  localparam int SpinAdd   = (SpinBits < 16) ? 16 - SpinBits : 0;
  localparam int GradDrop  = (FieldBits > 24) ? FieldBits - 24 : 0;
  localparam int GradAdd   = (FieldBits < 24) ? 24 - FieldBits : 0;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_FIELD_SCALE = 8'd0,
    REG_NOISE_SCALE = 8'd1,
    REG_PREC_GAIN   = 8'd2,
    REG_DAMP_GAIN   = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [SpinBits-1:0]  spin_x;
    logic signed [SpinBits-1:0]  spin_y;
    logic signed [SpinBits-1:0]  spin_z;
    logic signed [FieldBits-1:0] grad_x;
    logic signed [FieldBits-1:0] grad_y;
    logic signed [FieldBits-1:0] grad_z;
    logic signed [NoiseBits-1:0] noise_x;
    logic signed [NoiseBits-1:0] noise_y;
    logic signed [NoiseBits-1:0] noise_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SpinBits-1:0] new_spin_x;
    logic signed [SpinBits-1:0] new_spin_y;
    logic signed [SpinBits-1:0] new_spin_z;
  } out_item_t;

  typedef struct packed {
    logic signed [RegBits-1:0] field_scale;
    logic [RegBits-1:0]        noise_scale;
    logic [RegBits-1:0]        precession_gain;
    logic [RegBits-1:0]        damping_gain;
  } cfg_t;

  typedef logic [2:0][NBits-1:0] n_vec_t;

  typedef struct packed {
    logic [2:0][SaBits-1:0] mag;
    logic [RootBits-1:0]    root;
    logic [2:0]             neg;
    logic                   zero;
  } norm_t;

  function automatic logic signed [15:0] spin_to_q15(input logic signed [SpinBits-1:0] s);
    logic signed [63:0] t;
    t = 64'(s);
    if (SpinBits > 16) t = t >>> SpinDrop;
    else t = t <<< SpinAdd;
    return t[15:0];
  endfunction

  function automatic logic signed [23:0] grad_to_q16(input logic signed [FieldBits-1:0] g);
    logic signed [63:0] t;
    t = 64'(g);
    if (FieldBits > 24) t = t >>> GradDrop;
    else t = t <<< GradAdd;
    return t[23:0];
  endfunction

  function automatic int idx_next(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int idx_prev(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

endpackage

// ----- rtl/sllg_torque.sv -----
// sllg_torque: effective field, precession and damping terms, unnormalised spin
// nine register stages; depends on sllg_pkg
`timescale 1ns / 1ps
module sllg_torque
  import sllg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     valid_o,
  output n_vec_t   n_o
);

  localparam logic signed [37:0] HMax = 38'sd2147483647;
  localparam logic signed [37:0] HMin = -38'sd2147483648;

  logic signed [SpinBits-1:0]  sp [3];
  logic signed [FieldBits-1:0] gr [3];
  logic signed [NoiseBits-1:0] nz [3];

  assign sp[0] = item_i.spin_x;
  assign sp[1] = item_i.spin_y;
  assign sp[2] = item_i.spin_z;
  assign gr[0] = item_i.grad_x;
  assign gr[1] = item_i.grad_y;
  assign gr[2] = item_i.grad_z;
  assign nz[0] = item_i.noise_x;
  assign nz[1] = item_i.noise_y;
  assign nz[2] = item_i.noise_z;

  logic [8:0] v_q;

  logic signed [15:0]      s_q    [8][3];
  logic signed [55:0]      pf1_q  [3];
  logic signed [48:0]      pn1_q  [3];
  logic signed [HBits-1:0] h2_q   [3];
  logic signed [47:0]      pa3_q  [3];
  logic signed [47:0]      pb3_q  [3];
  logic signed [CBits-1:0] c4_q   [3];
  logic signed [49:0]      pa5_q  [3];
  logic signed [49:0]      pb5_q  [3];
  logic signed [CBits-1:0] c5_q   [3];
  logic signed [EBits-1:0] e6_q   [3];
  logic signed [CBits-1:0] c6_q   [3];
  logic [63:0]             lop7_q [3];
  logic [MagBits-1:0]      hip7_q [3];
  logic [63:0]             lod7_q [3];
  logic [MagBits-1:0]      hid7_q [3];
  logic [2:0]              negc7_q, nege7_q;
  logic [MagBits-1:0]      rp8_q  [3];
  logic [MagBits-1:0]      rd8_q  [3];
  logic [2:0]              negc8_q, nege8_q;
  logic signed [NBits-1:0] n9_q   [3];

  logic signed [37:0]      hsum   [3];
  logic signed [HBits-1:0] h2_d   [3];
  logic signed [48:0]      dc     [3];
  logic signed [50:0]      de     [3];
  logic [MagBits:0]        magc   [3];
  logic [MagBits:0]        mage   [3];
  logic [MagBits-1:0]      rp8_d  [3];
  logic [MagBits-1:0]      rd8_d  [3];
  logic signed [NBits-1:0] n9_d   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[7:0], valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hsum[i] = 38'(pf1_q[i] >>> 24) + 38'(pn1_q[i] >>> 12);
      if (hsum[i] > HMax) begin
        h2_d[i] = 32'sh7fffffff;
      end else if (hsum[i] < HMin) begin
        h2_d[i] = 32'sh80000000;
      end else begin
        h2_d[i] = hsum[i][HBits-1:0];
      end
      dc[i]    = 49'(pa3_q[i]) - 49'(pb3_q[i]);
      de[i]    = 51'(pa5_q[i]) - 51'(pb5_q[i]);
      magc[i]  = (c6_q[i] < 0) ? (MagBits+1)'(-(MagBits+1)'(c6_q[i]))
                                : (MagBits+1)'(c6_q[i]);
      mage[i]  = (e6_q[i] < 0) ? (MagBits+1)'(-(MagBits+1)'(e6_q[i]))
                                : (MagBits+1)'(e6_q[i]);
      rp8_d[i] = hip7_q[i] + MagBits'(lop7_q[i][63:32]);
      rd8_d[i] = hid7_q[i] + MagBits'(lod7_q[i][63:32]);
      // the precession and damping terms carry the opposite signs of c and e
      n9_d[i]  = (NBits'(s_q[7][i]) <<< 1)
               + (negc8_q[i] ? NBits'(rp8_q[i]) : -NBits'(rp8_q[i]))
               + (nege8_q[i] ? NBits'(rd8_q[i]) : -NBits'(rd8_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s_q[0][i] <= spin_to_q15(sp[i]);
        for (int st = 1; st < 8; st++) begin
          s_q[st][i] <= s_q[st-1][i];
        end
        pf1_q[i]  <= cfg_i.field_scale * grad_to_q16(gr[i]);
        pn1_q[i]  <= $signed({1'b0, cfg_i.noise_scale}) * nz[i];
        h2_q[i]   <= h2_d[i];
        pa3_q[i]  <= s_q[1][idx_next(i)] * h2_q[idx_prev(i)];
        pb3_q[i]  <= s_q[1][idx_prev(i)] * h2_q[idx_next(i)];
        c4_q[i]   <= CBits'(dc[i] >>> 15);
        pa5_q[i]  <= s_q[3][idx_next(i)] * c4_q[idx_prev(i)];
        pb5_q[i]  <= s_q[3][idx_prev(i)] * c4_q[idx_next(i)];
        c5_q[i]   <= c4_q[i];
        e6_q[i]   <= EBits'(de[i] >>> 15);
        c6_q[i]   <= c5_q[i];
        lop7_q[i] <= 64'(magc[i][31:0]) * 64'(cfg_i.precession_gain);
        hip7_q[i] <= MagBits'(magc[i][MagBits-1:32]) * MagBits'(cfg_i.precession_gain);
        lod7_q[i] <= 64'(mage[i][31:0]) * 64'(cfg_i.damping_gain);
        hid7_q[i] <= MagBits'(mage[i][MagBits-1:32]) * MagBits'(cfg_i.damping_gain);
        negc7_q[i] <= c6_q[i] < 0;
        nege7_q[i] <= e6_q[i] < 0;
        rp8_q[i]  <= rp8_d[i];
        rd8_q[i]  <= rd8_d[i];
        negc8_q[i] <= negc7_q[i];
        nege8_q[i] <= nege7_q[i];
        n9_q[i]   <= n9_d[i];
      end
    end
  end

  assign valid_o = v_q[8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_o[i] = n9_q[i];
    end
  end

endmodule

// ----- rtl/sllg_norm.sv -----
// sllg_norm: magnitudes, power-of-two scaling, sum of squares and pipelined square root
// six setup stages plus one stage per root bit; depends on sllg_pkg
`timescale 1ns / 1ps
module sllg_norm
  import sllg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  n_vec_t n_i,
  output logic   valid_o,
  output norm_t  norm_o
);

  localparam int SqrtSteps = RootBits;
  localparam int TrialBits = SqBits + 1;
  localparam int PosBits   = $clog2(ABits);
  localparam logic [PosBits-1:0] TopPos = PosBits'(SaBits - 1);

  logic [4:0]         vn_q;
  logic [SqrtSteps:0] sv_q;

  logic [ABits-1:0]   a1_q [3];
  logic [2:0]         neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [ABits-1:0]   a2_q [3];
  logic [ABits-1:0]   mx2_q;
  logic               zero2_q, zero3_q, zero4_q, zero5_q;
  logic [ABits-1:0]   a3_q [3];
  logic               right3_q;
  logic [PosBits-1:0] amt3_q;
  logic [SaBits-1:0]  sa4_q [3];
  logic [SaBits-1:0]  sa5_q [3];
  logic [2*SaBits-1:0] sq5_q [3];

  logic [SqBits-1:0]   rem_q  [SqrtSteps+1];
  logic [RootBits-1:0] root_q [SqrtSteps+1];
  logic [SaBits-1:0]   sa_q   [SqrtSteps+1][3];
  logic [2:0]          neg_q  [SqrtSteps+1];
  logic                zero_q [SqrtSteps+1];

  logic [NBits-1:0]   abs_d [3];
  logic [ABits-1:0]   m01;
  logic [ABits-1:0]   mx_d;
  logic [PosBits-1:0] pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= '0;
      sv_q <= '0;
    end else if (en_i) begin
      {sv_q, vn_q} <= {sv_q[SqrtSteps-1:0], vn_q, valid_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = n_i[i][NBits-1] ? -n_i[i] : n_i[i];
    end
    m01  = (a1_q[0] > a1_q[1]) ? a1_q[0] : a1_q[1];
    mx_d = (m01 > a1_q[2]) ? m01 : a1_q[2];
    // position of the leading one
    pos = '0;
    for (int b = 0; b < ABits; b++) begin
      if (mx2_q[b]) pos = PosBits'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i]  <= abs_d[i][ABits-1:0];
        neg1_q[i] <= n_i[i][NBits-1];
        a2_q[i]  <= a1_q[i];
        a3_q[i]  <= a2_q[i];
        sa4_q[i] <= right3_q ? SaBits'(a3_q[i] >> amt3_q) : SaBits'(a3_q[i] << amt3_q);
        sa5_q[i] <= sa4_q[i];
        sq5_q[i] <= sa4_q[i] * sa4_q[i];
        sa_q[0][i] <= sa5_q[i];
      end
      mx2_q    <= mx_d;
      zero2_q  <= (mx_d == '0);
      neg2_q   <= neg1_q;
      right3_q <= pos >= TopPos;
      amt3_q   <= (pos >= TopPos) ? pos - TopPos : TopPos - pos;
      zero3_q  <= zero2_q;
      neg3_q   <= neg2_q;
      zero4_q  <= zero3_q;
      neg4_q   <= neg3_q;
      zero5_q  <= zero4_q;
      neg5_q   <= neg4_q;
      rem_q[0]  <= SqBits'(sq5_q[0]) + SqBits'(sq5_q[1]) + SqBits'(sq5_q[2]);
      root_q[0] <= '0;
      neg_q[0]  <= neg5_q;
      zero_q[0] <= zero5_q;
    end
  end

  // one root bit per stage, remainder kept as x - root^2
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int K = SqrtSteps - 1 - j;
    logic [TrialBits-1:0] trial;
    logic take;

    always_comb begin
      trial = (TrialBits'(root_q[j]) << (K + 1)) | (TrialBits'(1) << (2 * K));
      take  = {1'b0, rem_q[j]} >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= take ? rem_q[j] - trial[SqBits-1:0] : rem_q[j];
        root_q[j+1] <= take ? (root_q[j] | (RootBits'(1) << K)) : root_q[j];
        sa_q[j+1]   <= sa_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  assign valid_o = sv_q[SqrtSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_o.mag[i] = sa_q[SqrtSteps][i];
    end
    norm_o.root = root_q[SqrtSteps];
    norm_o.neg  = neg_q[SqrtSteps];
    norm_o.zero = zero_q[SqrtSteps];
  end

`ifndef SYNTHESIS
  a_scaled_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vn_q[3] && !zero4_q |-> (sa4_q[0][SaBits-1] || sa4_q[1][SaBits-1] || sa4_q[2][SaBits-1]))
    else $error("largest scaled magnitude not in top octave");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[SqrtSteps] && !zero_q[SqrtSteps] |-> root_q[SqrtSteps][RootBits-1:RootBits-2] != 2'b00)
    else $error("square root below expected range");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[SqrtSteps] |-> rem_q[SqrtSteps] <= SqBits'({root_q[SqrtSteps], 1'b0}))
    else $error("square root remainder too large");
`endif

endmodule

// ----- rtl/sllg_scale.sv -----
// sllg_scale: rounded division of each magnitude by the root, saturation and sign
// numerator register, one stage per quotient bit and output register; depends on sllg_pkg
`timescale 1ns / 1ps
module sllg_scale
  import sllg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  norm_t     norm_i,
  output logic      valid_o,
  output out_item_t item_o
);

  localparam int QBits = SpinBits;
  localparam int DW    = SaBits + SpinBits;
  localparam int TW    = DW + 1;
  localparam logic [QBits-1:0] Lim    = {1'b0, {(QBits-1){1'b1}}};
  localparam logic [QBits-1:0] LimNeg = {1'b1, {(QBits-1){1'b0}}};

  logic [QBits:0]        dv_q;
  logic                  ov_q;
  logic [DW-1:0]         rem_q  [QBits+1][3];
  logic [QBits-1:0]      quo_q  [QBits+1][3];
  logic [RootBits-1:0]   root_q [QBits+1];
  logic [2:0]            neg_q  [QBits+1];
  logic                  zero_q [QBits+1];
  logic signed [QBits-1:0] res_q [3];

  logic [QBits-1:0]        mag_d [3];
  logic signed [QBits-1:0] res_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      {ov_q, dv_q} <= {dv_q, valid_i};
    end
  end

  // numerator with half the divisor added for round-half-up
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= DW'({norm_i.mag[i], {(SpinBits-1){1'b0}}}) + DW'(norm_i.root >> 1);
        quo_q[0][i] <= '0;
      end
      root_q[0] <= norm_i.root;
      neg_q[0]  <= norm_i.neg;
      zero_q[0] <= norm_i.zero;
    end
  end

  for (genvar j = 0; j < QBits; j++) begin : g_div
    localparam int K = QBits - 1 - j;
    logic [TW-1:0] trial;
    logic [2:0]    take;

    always_comb begin
      trial = TW'(root_q[j]) << K;
      for (int i = 0; i < 3; i++) begin
        take[i] = {1'b0, rem_q[j][i]} >= trial;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[j+1][i] <= take[i] ? rem_q[j][i] - trial[DW-1:0] : rem_q[j][i];
          quo_q[j+1][i] <= take[i] ? (quo_q[j][i] | (QBits'(1) << K)) : quo_q[j][i];
        end
        root_q[j+1] <= root_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // +1.0 is clipped, -1.0 is representable
      if (neg_q[QBits][i]) begin
        mag_d[i] = (quo_q[QBits][i] > LimNeg) ? LimNeg : quo_q[QBits][i];
        res_d[i] = -$signed(mag_d[i]);
      end else begin
        mag_d[i] = (quo_q[QBits][i] > Lim) ? Lim : quo_q[QBits][i];
        res_d[i] = $signed(mag_d[i]);
      end
      if (zero_q[QBits]) res_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  assign valid_o           = ov_q;
  assign item_o.new_spin_x = res_q[0];
  assign item_o.new_spin_y = res_q[1];
  assign item_o.new_spin_z = res_q[2];

endmodule

// ----- rtl/stochastic_llg_spin_update.sv -----
// stochastic_llg_spin_update: top level, configuration registers and pipeline control
// instantiates sllg_torque, sllg_norm and sllg_scale; depends on sllg_pkg
`timescale 1ns / 1ps
// One explicit Euler step of the stochastic LLG equation per spin.
// Input channel in_valid_i / in_ready_o / in_data_i carries the spin, the energy
// gradient and three normal noise samples; output channel out_valid_o / out_ready_i /
// out_data_o returns the renormalised, saturated spin, one result per request.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 field_scale,
// 1 noise_scale, 2 precession_gain, 3 damping_gain) and cfg_data_i; other indexes
// are ignored. cfg_ready_o is always high; write only while no request is in flight.
// From acceptance to out_valid_o the pipeline has 9 stages for field and torque,
// 6 for scaling and the sum of squares, 31 for the bit-per-stage square root,
// 17 for the bit-per-stage divider and one output register.
// Throughput is one request per clock while the receiver takes results.
// When out_valid_o is high and out_ready_i low the whole pipeline holds and
// in_ready_o drops; nothing is lost or repeated.
// Reset empties the pipeline and loads field_scale with -1.0, the other gains with 0.
module stochastic_llg_spin_update
  import sllg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [RegBits-1:0]    cfg_data_i
);

  cfg_t   cfg_q;
  logic   en;
  logic   tq_valid;
  n_vec_t tq_n;
  logic   nm_valid;
  norm_t  nm_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_scale     <= 32'shFF000000;
      cfg_q.noise_scale     <= '0;
      cfg_q.precession_gain <= '0;
      cfg_q.damping_gain    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FIELD_SCALE: cfg_q.field_scale     <= $signed(cfg_data_i);
        REG_NOISE_SCALE: cfg_q.noise_scale     <= cfg_data_i;
        REG_PREC_GAIN:   cfg_q.precession_gain <= cfg_data_i;
        REG_DAMP_GAIN:   cfg_q.damping_gain    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // the pipeline moves unless a finished result is waiting
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  sllg_torque u_torque (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (tq_valid),
    .n_o     (tq_n)
  );

  sllg_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tq_valid),
    .n_i     (tq_n),
    .valid_o (nm_valid),
    .norm_o  (nm_data)
  );

  sllg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid),
    .norm_i  (nm_data),
    .valid_o (out_valid_o),
    .item_o  (out_data_o)
  );

endmodule
